[src/prbf_pkg.sv]
// Shared types and constants of the port range bitmap filter.
// No dependencies; every other file of the block but prbf_ram imports this package.
package prbf_pkg;

    localparam int PORT_W      = 16;
    localparam int OP_W        = 2;
    localparam int SEL_W       = 3;
    localparam int NUM_SETS    = 6;
    localparam int TDATA_IN_W  = 64;
    localparam int TUSER_IN_W  = 5;
    localparam int TDATA_OUT_W = 8;
    localparam int TUSER_OUT_W = 1;

    // Item kinds carried in the low bits of the slave-side tuser
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

    // Bitmap selectors
    localparam logic [SEL_W-1:0] SET_INC_ANY = 3'd0;
    localparam logic [SEL_W-1:0] SET_INC_A   = 3'd1;
    localparam logic [SEL_W-1:0] SET_INC_B   = 3'd2;
    localparam logic [SEL_W-1:0] SET_EXC_ANY = 3'd3;
    localparam logic [SEL_W-1:0] SET_EXC_A   = 3'd4;
    localparam logic [SEL_W-1:0] SET_EXC_B   = 3'd5;
    localparam logic [SEL_W-1:0] SET_LIMIT   = 3'd6;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_ADD_RD,
        S_ADD_WR,
        S_CLS_RD,
        S_CLS_EV,
        S_RESULT
    } prbf_state_t;

    typedef struct packed {
        logic capture;
        logic sweep_step;
        logic add_read;
        logic add_write;
        logic eval;
        logic load_out;
    } prbf_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic            in_bad_range;
        logic            in_sel_ok;
        logic            sweep_end;
        logic            add_end;
        logic            out_free;
    } prbf_stat_t;

endpackage

[src/prbf_ram.sv]
// Bitmap word store: one write port, two read ports with registered data.
// No dependencies.
module prbf_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[src/prbf_ctrl.sv]
// Sequencer of the port range bitmap filter: walks each item through its steps.
// Depends on prbf_pkg for the state, command and status types.
module prbf_ctrl
    import prbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  prbf_stat_t stat,
    output prbf_cmd_t  cmd
);

    prbf_state_t state_reg;
    prbf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    case (stat.in_op)
                        OP_CLEAR:    state_next = S_CLEAR;
                        OP_CLASSIFY: state_next = S_CLS_RD;
                        OP_ADD:
                        begin
                            if (stat.in_bad_range || !stat.in_sel_ok)
                            begin
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_ADD_RD;
                            end
                        end
                        default:     state_next = S_RESULT;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_end)
                begin
                    state_next = S_RESULT;
                end
            end
            S_ADD_RD:
            begin
                cmd.add_read = 1'b1;
                state_next   = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.add_write = 1'b1;
                state_next    = stat.add_end ? S_RESULT : S_ADD_RD;
            end
            S_CLS_RD:
            begin
                state_next = S_CLS_EV;
            end
            S_CLS_EV:
            begin
                cmd.eval   = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A word write always follows the read of that same word
    a_add_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD_WR |-> $past(state_reg) == S_ADD_RD)
        else $error("word write without preceding read");

    // Classification evaluates only once the bitmap words have been read
    a_cls_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLS_EV |-> $past(state_reg) == S_CLS_RD)
        else $error("classify evaluated before read");

    // A result is loaded only when the output stage can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded into occupied output stage");
`endif

endmodule

[src/prbf_dpath.sv]
// Datapath of the port range bitmap filter: item registers, range walker,
// six bitmap stores, hit logic and output stage. Depends on prbf_pkg and prbf_ram.
module prbf_dpath
    import prbf_pkg::*;
#(
    parameter int PORT_BITS = 16,
    parameter int WORD_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic [TUSER_IN_W-1:0]  s_tuser,
    input  prbf_cmd_t              cmd,
    output prbf_stat_t             stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic [TUSER_OUT_W-1:0] m_tuser
);

    localparam int WORDS  = ((1 << PORT_BITS) + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam logic [PORT_W-1:0] PORT_MASK = PORT_W'((32'd1 << PORT_BITS) - 32'd1);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);
    localparam logic [BIT_W-1:0]  TOP_BIT   = BIT_W'(WORD_BITS - 1);

    // Input decode
    logic [OP_W-1:0]   in_op;
    logic [SEL_W-1:0]  in_sel;
    logic [PORT_W-1:0] in_first;
    logic [PORT_W-1:0] in_last;
    logic [PORT_W-1:0] in_pa;
    logic [PORT_W-1:0] in_pb;

    assign in_op    = s_tuser[OP_W-1:0];
    assign in_sel   = s_tuser[OP_W +: SEL_W];
    assign in_first = s_tdata[0 +: PORT_W] & PORT_MASK;
    assign in_last  = s_tdata[PORT_W +: PORT_W] & PORT_MASK;
    assign in_pa    = s_tdata[2*PORT_W +: PORT_W] & PORT_MASK;
    assign in_pb    = s_tdata[3*PORT_W +: PORT_W] & PORT_MASK;

    // Item registers
    logic [SEL_W-1:0]  sel_reg;
    logic [ADDR_W-1:0] first_word_reg;
    logic [ADDR_W-1:0] last_word_reg;
    logic [BIT_W-1:0]  first_bit_reg;
    logic [BIT_W-1:0]  last_bit_reg;
    logic [ADDR_W-1:0] a_word_reg;
    logic [ADDR_W-1:0] b_word_reg;
    logic [BIT_W-1:0]  a_bit_reg;
    logic [BIT_W-1:0]  b_bit_reg;
    logic              res_match_reg;
    logic              res_status_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sel_reg        <= in_sel;
            first_word_reg <= ADDR_W'(in_first >> BIT_W);
            last_word_reg  <= ADDR_W'(in_last >> BIT_W);
            first_bit_reg  <= in_first[BIT_W-1:0];
            last_bit_reg   <= in_last[BIT_W-1:0];
            a_word_reg     <= ADDR_W'(in_pa >> BIT_W);
            b_word_reg     <= ADDR_W'(in_pb >> BIT_W);
            a_bit_reg      <= in_pa[BIT_W-1:0];
            b_bit_reg      <= in_pb[BIT_W-1:0];
        end
    end

    // Walk counter and active flags
    logic [ADDR_W-1:0]   walk_reg;
    logic [ADDR_W-1:0]   walk_next;
    logic [NUM_SETS-1:0] active_reg;
    logic [NUM_SETS-1:0] active_next;

    always_comb
    begin
        walk_next   = walk_reg;
        active_next = active_reg;
        if (cmd.capture)
        begin
            walk_next = (in_op == OP_CLEAR) ? '0 : ADDR_W'(in_first >> BIT_W);
            if (in_op == OP_CLEAR)
            begin
                active_next = '0;
            end
            else if (in_op == OP_ADD && in_first <= in_last && in_sel < SET_LIMIT)
            begin
                active_next = active_reg | NUM_SETS'(1 << in_sel);
            end
        end
        else if (cmd.sweep_step || cmd.add_write)
        begin
            walk_next = walk_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg   <= '0;
            active_reg <= '0;
        end
        else
        begin
            walk_reg   <= walk_next;
            active_reg <= active_next;
        end
    end

    // Bitmap stores
    logic [WORD_BITS-1:0] rdata_a [NUM_SETS];
    logic [WORD_BITS-1:0] rdata_b [NUM_SETS];
    logic [WORD_BITS-1:0] sel_word;
    logic [WORD_BITS-1:0] fill_mask;
    logic [WORD_BITS-1:0] wr_data;
    logic [NUM_SETS-1:0]  wr_en;
    logic [ADDR_W-1:0]    rd_addr_a;
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     hi_bit;

    assign rd_addr_a = cmd.add_read ? walk_reg : a_word_reg;

    // Span of bits to set in the current word of the range
    assign lo_bit    = (walk_reg == first_word_reg) ? first_bit_reg : '0;
    assign hi_bit    = (walk_reg == last_word_reg) ? last_bit_reg : TOP_BIT;
    assign fill_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                       ({WORD_BITS{1'b1}} >> (TOP_BIT - hi_bit));

    always_comb
    begin
        sel_word = '0;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            if (sel_reg == SEL_W'(s))
            begin
                sel_word = rdata_a[s];
            end
        end
    end

    assign wr_data = cmd.sweep_step ? '0 : (sel_word | fill_mask);

    for (genvar g = 0; g < NUM_SETS; g++)
    begin : g_set
        assign wr_en[g] = cmd.sweep_step || (cmd.add_write && sel_reg == SEL_W'(g));

        prbf_ram #(
            .DEPTH  (WORDS),
            .WIDTH  (WORD_BITS),
            .ADDR_W (ADDR_W)
        ) u_ram (
            .clk       (clk),
            .wr_en     (wr_en[g]),
            .wr_addr   (walk_reg),
            .wr_data   (wr_data),
            .rd_addr_a (rd_addr_a),
            .rd_addr_b (b_word_reg),
            .rd_data_a (rdata_a[g]),
            .rd_data_b (rdata_b[g])
        );
    end

    // Hit logic
    logic inc_none;
    logic inc_hit;
    logic exc_hit;

    assign inc_none = (active_reg[SET_INC_B:SET_INC_ANY] == '0);
    assign inc_hit  = rdata_a[SET_INC_ANY][a_bit_reg] || rdata_b[SET_INC_ANY][b_bit_reg] ||
                      rdata_a[SET_INC_A][a_bit_reg]   || rdata_b[SET_INC_B][b_bit_reg];
    assign exc_hit  = rdata_a[SET_EXC_ANY][a_bit_reg] || rdata_b[SET_EXC_ANY][b_bit_reg] ||
                      rdata_a[SET_EXC_A][a_bit_reg]   || rdata_b[SET_EXC_B][b_bit_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_match_reg  <= 1'b0;
            res_status_reg <= (in_op == OP_ADD) && (in_first > in_last);
        end
        else if (cmd.eval)
        begin
            res_match_reg <= (inc_none || inc_hit) && !exc_hit;
        end
    end

    // Output stage
    logic out_valid_reg;
    logic out_match_reg;
    logic out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_match_reg  <= res_match_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-1){1'b0}}, out_match_reg};
    assign m_tuser  = out_status_reg;

    // Status to the sequencer
    assign stat.in_op        = in_op;
    assign stat.in_bad_range = (in_first > in_last);
    assign stat.in_sel_ok    = (in_sel < SET_LIMIT);
    assign stat.sweep_end    = (walk_reg == LAST_WORD);
    assign stat.add_end      = (walk_reg == last_word_reg);
    assign stat.out_free     = !out_valid_reg || m_tready;

`ifndef NO_ASSERTIONS
    // The range walk never passes the last word of the range
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_write |-> walk_reg <= last_word_reg)
        else $error("range walk beyond last word");

    // Only a valid bitmap is ever written by a range load
    a_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_write |-> sel_reg < SET_LIMIT)
        else $error("range write to unknown bitmap");

    // A clear drops every active flag
    a_clear_flags: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture && in_op == OP_CLEAR |=> active_reg == '0)
        else $error("active flags survive clear");
`endif

endmodule

[src/port_range_bitmap_filter.sv]
// Top level of the port range bitmap filter: stream ports, sequencer and datapath.
// Depends on prbf_pkg, prbf_ctrl and prbf_dpath.
//
// Six port bitmaps (include either/A/B, exclude either/A/B) of 2^PORT_BITS bits
// each are held in six word-wide stores of WORD_BITS bits (WORD_BITS a power of
// two). Each input item gives exactly one result item. Steps per item, counted
// from acceptance: classify goes through capture, word read, evaluate and load
// output; add-range walks the bitmap words the range spans, and every word goes
// through a read and a write on the store's single write port; a reversed range
// or unknown bitmap, and an unknown op, go straight to the result; clear sweeps
// all words to zero, one row of the six stores per cycle. After reset the same
// sweep runs with s_tready low. A finished result sits in an output register,
// so the next item is taken while the previous result waits; a result then
// holds in the sequencer until the output register frees.
module port_range_bitmap_filter
    import prbf_pkg::*;
#(
    parameter int PORT_BITS = 16,
    parameter int WORD_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [15:0] range_first, [31:16] range_last, [47:32] port_a, [63:48] port_b
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // [1:0] op, [4:2] set_select
    input  logic [TUSER_IN_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] match, [7:1] zero
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // [0] status
    output logic [TUSER_OUT_W-1:0] m_tuser
);

    prbf_cmd_t  cmd;
    prbf_stat_t stat;

    // Sequencer: one item at a time, issue read/write/sweep steps
    prbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: bitmap stores, range walker, hit logic, output register
    prbf_dpath #(
        .PORT_BITS (PORT_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[tb/port_range_bitmap_filter_test.sv]
// Self-checking testbench for port_range_bitmap_filter: directed, random and backpressure items.
// Depends on prbf_pkg and the port_range_bitmap_filter RTL; needs no other file.
module port_range_bitmap_filter_test;
    import prbf_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int RANDOM_ITEMS = 400;
    localparam int WORD_W       = 64;
    localparam int MAP_WORDS    = (1 << PORT_W) / WORD_W;
    localparam int PORT_TOP     = (1 << PORT_W) - 1;

    localparam logic [PORT_W-1:0] PORT_MAX = '1;

    // Codes the block must tolerate but the package does not name
    localparam logic [OP_W-1:0]  OP_SPARE  = 2'd3;
    localparam logic [SEL_W-1:0] SET_SPARE = 3'd7;

    typedef struct packed {
        logic admit;
        logic bad_range;
    } verdict_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic [TUSER_IN_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;

    // Shadow copy of the six bitmaps and their active flags
    bit [WORD_W-1:0]   map_words [NUM_SETS][MAP_WORDS];
    bit [NUM_SETS-1:0] map_live;

    verdict_t verdict_q[$];     // one verdict per accepted item, oldest first
    int       range_lo_q[$];    // ranges loaded in the current filter, for aiming ports
    int       range_hi_q[$];
    int       fail_count   = 0;
    int       send_gap_pct = 19;
    int       recv_gap_pct = 19;
    int       hold_left    = 0; // cycles the receiver still refuses results

    port_range_bitmap_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Filter predictor
    // ------------------------------------------------------------------

    // A port hits a bitmap only while that bitmap is active
    function automatic bit map_has(logic [SEL_W-1:0] set_idx, logic [PORT_W-1:0] port);
        return map_live[set_idx] && map_words[set_idx][port / WORD_W][port % WORD_W];
    endfunction

    function automatic void map_clear();
        for (int s = 0; s < NUM_SETS; s++)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                map_words[s][w] = '0;
            end
        end
        map_live = '0;
    endfunction

    // Set bits lo..hi inclusive, one word mask at a time
    function automatic void map_fill(int set_idx, int lo, int hi);
        bit [WORD_W-1:0] ones;
        int              lo_bit;
        int              hi_bit;
        ones = '1;
        map_live[set_idx] = 1'b1;
        for (int w = lo / WORD_W; w <= hi / WORD_W; w++)
        begin
            lo_bit = (w == lo / WORD_W) ? lo % WORD_W : 0;
            hi_bit = (w == hi / WORD_W) ? hi % WORD_W : WORD_W - 1;
            map_words[set_idx][w] |= (ones << lo_bit) & (ones >> (WORD_W - 1 - hi_bit));
        end
    endfunction

    // Apply one item to the shadow state and return the result it must give
    function automatic verdict_t filter_verdict(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel,
                                                logic [PORT_W-1:0] first, logic [PORT_W-1:0] last,
                                                logic [PORT_W-1:0] pa, logic [PORT_W-1:0] pb);
        verdict_t v;
        bit       inc_none;
        bit       inc_hit;
        bit       exc_hit;
        v = '0;
        case (op)
            OP_CLEAR:
            begin
                map_clear();
            end
            OP_ADD:
            begin
                // a reversed range is refused whatever the selector says
                if (first > last)
                    v.bad_range = 1'b1;
                else if (sel < SET_LIMIT)
                    map_fill(int'(sel), int'(first), int'(last));
            end
            OP_CLASSIFY:
            begin
                inc_none = !(map_live[SET_INC_ANY] || map_live[SET_INC_A] || map_live[SET_INC_B]);
                inc_hit  = map_has(SET_INC_ANY, pa) || map_has(SET_INC_ANY, pb) ||
                           map_has(SET_INC_A, pa) || map_has(SET_INC_B, pb);
                exc_hit  = map_has(SET_EXC_ANY, pa) || map_has(SET_EXC_ANY, pb) ||
                           map_has(SET_EXC_A, pa) || map_has(SET_EXC_B, pb);
                v.admit  = (inc_none || inc_hit) && !exc_hit;
            end
            default:
            begin
                // spare op: no change, zero result
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Random field values for fields an item does not use
    function automatic logic [PORT_W-1:0] any_port();
        return PORT_W'($urandom);
    endfunction

    function automatic logic [SEL_W-1:0] any_sel();
        return SEL_W'($urandom);
    endfunction

    // Offer one item, idling first at random; return at the edge that takes it.
    // Valid is left high so a following item can go out without a gap.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                             input logic [PORT_W-1:0] first, input logic [PORT_W-1:0] last,
                             input logic [PORT_W-1:0] pa, input logic [PORT_W-1:0] pb);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct) gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pb, pa, last, first};
        s_tuser  <= {sel, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        verdict_q.insert(verdict_q.size(), filter_verdict(op, sel, first, last, pa, pb));
    endtask

    // Hold the sender until every outstanding result has been returned
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
    endtask

    // Aim a port at a loaded range edge or interior, an extreme, or anywhere
    function automatic logic [PORT_W-1:0] pick_port();
        logic [PORT_W-1:0] port;
        int                roll;
        int                k;
        roll = $urandom_range(99);
        port = PORT_W'($urandom);
        if (roll < 50 && range_lo_q.size() > 0)
        begin
            k = $urandom_range(range_lo_q.size() - 1);
            case ($urandom_range(3))
                0:       port = PORT_W'(range_lo_q[k] - 1);
                1:       port = PORT_W'(range_lo_q[k]);
                2:       port = PORT_W'(range_hi_q[k] + 1);
                default: port = PORT_W'($urandom_range(range_hi_q[k], range_lo_q[k]));
            endcase
        end
        else if (roll < 60)
        begin
            port = $urandom_range(1) ? PORT_MAX : '0;
        end
        return port;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side and result checking
    // ------------------------------------------------------------------

    // Refuse results at random, or for a counted stretch when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: expected none, got tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (m_tdata !== {{(TDATA_OUT_W - 1){1'b0}}, want.admit})
                begin
                    $display("%0t: match field: expected %h, got %h", $time,
                             {{(TDATA_OUT_W - 1){1'b0}}, want.admit}, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.bad_range)
                begin
                    $display("%0t: status field: expected %h, got %h", $time,
                             want.bad_range, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No bitmap active: every pair passes, extremes included
    task automatic test_empty_filter();
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), '0, PORT_MAX);
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), PORT_MAX, '0);
    endtask

    // Each include bitmap, with single-port ranges at both ends of the port space
    task automatic test_include_sets();
        send_item(OP_ADD, SET_INC_ANY, 16'd100, 16'd200, any_port(), any_port());
        send_item(OP_ADD, SET_INC_A, 16'd0, 16'd0, any_port(), any_port());
        send_item(OP_ADD, SET_INC_B, PORT_MAX, PORT_MAX, any_port(), any_port());
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd5000, 16'd150);
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd0, 16'd5000);
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd5000, PORT_MAX);
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), PORT_MAX, 16'd0);
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd99, 16'd201);
    endtask

    // Exclude bitmaps on top of the include ones; ranges that span word edges
    task automatic test_exclude_sets();
        send_item(OP_ADD, SET_EXC_ANY, 16'd150, 16'd150, any_port(), any_port());
        send_item(OP_ADD, SET_EXC_A, 16'd0, 16'd63, any_port(), any_port());
        send_item(OP_ADD, SET_EXC_B, 16'd64, 16'd191, any_port(), any_port());
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd7, 16'd150);
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd0, 16'd200);
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd199, 16'd64);
    endtask

    // Reversed range, unknown selector and spare op must leave the bitmaps alone
    task automatic test_odd_items();
        send_item(OP_ADD, SET_INC_A, 16'd10, 16'd9, any_port(), any_port());
        send_item(OP_ADD, SET_SPARE, PORT_MAX, 16'd0, any_port(), any_port());
        send_item(OP_ADD, SET_LIMIT, 16'd0, PORT_MAX, any_port(), any_port());
        send_item(OP_ADD, SET_SPARE, 16'd300, 16'd400, any_port(), any_port());
        send_item(OP_SPARE, any_sel(), any_port(), any_port(), any_port(), any_port());
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd350, 16'd9);
    endtask

    // Whole-space exclude rejects everything until a clear
    task automatic test_full_range_and_clear();
        send_item(OP_CLEAR, any_sel(), any_port(), any_port(), any_port(), any_port());
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd150, 16'd0);
        send_item(OP_ADD, SET_EXC_ANY, 16'd0, PORT_MAX, any_port(), any_port());
        send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), 16'd0, PORT_MAX);
        send_item(OP_CLEAR, any_sel(), any_port(), any_port(), any_port(), any_port());
    endtask

    // Stall the receiver long enough to fill the block while items keep coming
    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        range_lo_q.delete();
        range_hi_q.delete();
        send_item(OP_ADD, SET_INC_A, 16'd1000, 16'd1100, any_port(), any_port());
        range_lo_q.insert(range_lo_q.size(), 1000);
        range_hi_q.insert(range_hi_q.size(), 1100);
        send_item(OP_ADD, SET_EXC_B, 16'd1050, 16'd1060, any_port(), any_port());
        range_lo_q.insert(range_lo_q.size(), 1050);
        range_hi_q.insert(range_hi_q.size(), 1060);
        hold_left = 300;
        repeat (24)
        begin
            send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), pick_port(), pick_port());
        end
        drain_results();
        send_gap_pct = 19;
        recv_gap_pct = 19;
    endtask

    // Filters built from random ranges, each followed by a run of classifications.
    // The first filter runs with no idling on either side.
    task automatic test_random_filters();
        int sent;
        int width;
        int lo;
        int hi;
        int tmp;
        logic [SEL_W-1:0] sel;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            send_gap_pct = (sent == 0) ? 0 : 19;
            recv_gap_pct = (sent == 0) ? 0 : 19;
            range_lo_q.delete();
            range_hi_q.delete();
            send_item(OP_CLEAR, any_sel(), any_port(), any_port(), any_port(), any_port());
            sent++;
            repeat ($urandom_range(6, 1))
            begin
                // mostly narrow ranges; now and then the whole port space
                width = ($urandom_range(39) == 0) ? PORT_TOP : $urandom_range(300);
                lo    = $urandom_range(PORT_TOP - width);
                hi    = lo + width;
                sel   = ($urandom_range(14) == 0) ? SEL_W'($urandom_range(7, 6)) :
                                                    SEL_W'($urandom_range(5));
                if ($urandom_range(11) == 0 && lo != hi)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                else
                begin
                    range_lo_q.insert(range_lo_q.size(), lo);
                    range_hi_q.insert(range_hi_q.size(), hi);
                end
                send_item(OP_ADD, sel, PORT_W'(lo), PORT_W'(hi), any_port(), any_port());
                sent++;
            end
            repeat ($urandom_range(30, 10))
            begin
                // sprinkle spare ops and stray clears among the classifications
                if ($urandom_range(19) == 0)
                begin
                    send_item(OP_SPARE, any_sel(), any_port(), any_port(), any_port(),
                              any_port());
                end
                else if ($urandom_range(59) == 0)
                begin
                    range_lo_q.delete();
                    range_hi_q.delete();
                    send_item(OP_CLEAR, any_sel(), any_port(), any_port(), any_port(),
                              any_port());
                    sent++;
                end
                else
                begin
                    send_item(OP_CLASSIFY, any_sel(), any_port(), any_port(), pick_port(),
                              pick_port());
                    sent++;
                end
            end
        end
        send_gap_pct = 19;
        recv_gap_pct = 19;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        map_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_filter();
        test_include_sets();
        test_exclude_sets();
        test_odd_items();
        test_full_range_and_clear();
        drain_results();
        test_backpressure();
        test_random_filters();

        // let stray results surface before the verdict
        drain_results();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Give up after a fixed time, far beyond the slowest correct run
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule
